// ===== sv/rmth_pkg.sv =====
// Shared types and constants of the running median unit.
package rmth_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TOTAL_W  = 11;
  localparam int STATUS_W = 2;
  localparam int OUT_DATA_W = 32;

  typedef logic [SAMPLE_W-1:0] val_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_ACCEPTED  = 2'd0;
  localparam status_t ST_ENDED     = 2'd1;
  localparam status_t ST_IGNORED   = 2'd2;
  localparam status_t ST_RESTARTED = 2'd3;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic CFG_ACCEPT_LOW  = 1'b0;
  localparam logic CFG_ACCEPT_HIGH = 1'b1;

  localparam val_t ACCEPT_LOW_RESET  = 16'd0;
  localparam val_t ACCEPT_HIGH_RESET = 16'd99;

  // Command broadcast along a chain of sorted cells.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
    val_t value;
  } chain_cmd_t;

endpackage

// ===== sv/rmth_cell.sv =====
// One cell of a sorted chain: holds one value, inserts or shifts with its neighbors.
module rmth_cell import rmth_pkg::*; #(
  parameter bit IS_MAX = 1'b1
) (
  input  logic       clk,
  input  chain_cmd_t cmd,
  input  logic       occ,
  input  logic       prev_stay,
  input  val_t       prev_val,
  input  val_t       next_val,
  output val_t       val_r,
  output logic       stay
);

  val_t val_nxt;

  // A cell keeps its value on a push when it is occupied and ranks at least as high as the new one.
  assign stay = occ && (IS_MAX ? (val_r >= cmd.value) : (val_r <= cmd.value));

  always_comb begin
    val_nxt = val_r;
    if (cmd.push) begin
      if (!stay) begin
        val_nxt = prev_stay ? cmd.value : prev_val;
      end
    end else if (cmd.pop) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== sv/rmth_chain.sv =====
// Sorted chain of cells acting as a priority queue, with its fill count.
module rmth_chain import rmth_pkg::*; #(
  parameter int  DEPTH  = 513,
  parameter bit  IS_MAX = 1'b1,
  parameter int  SIZE_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  chain_cmd_t        cmd,
  output val_t              top,
  output logic [SIZE_W-1:0] size
);

  logic [SIZE_W-1:0] size_r, size_nxt;
  logic              full;
  logic              empty;
  chain_cmd_t        cell_cmd;
  val_t              vals  [DEPTH];
  logic              stays [DEPTH];

  assign full  = (size_r == SIZE_W'(DEPTH));
  assign empty = (size_r == '0);

  // A push into a full chain or a pop from an empty one is dropped.
  always_comb begin
    cell_cmd      = cmd;
    cell_cmd.push = cmd.push && !full && !cmd.clear;
    cell_cmd.pop  = cmd.pop && !empty && !cmd.push && !cmd.clear;
  end

  always_comb begin
    size_nxt = size_r;
    if (cmd.clear) begin
      size_nxt = '0;
    end else if (cell_cmd.push) begin
      size_nxt = size_r + SIZE_W'(1);
    end else if (cell_cmd.pop) begin
      size_nxt = size_r - SIZE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
    end else begin
      size_r <= size_nxt;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [SIZE_W-1:0] IDX = SIZE_W'(i);
    logic occ;
    logic prev_stay;
    val_t prev_val;
    val_t next_val;

    assign occ = (IDX < size_r);

    if (i == 0) begin : g_head
      assign prev_stay = 1'b1;
      assign prev_val  = '0;
    end else begin : g_body
      assign prev_stay = stays[i-1];
      assign prev_val  = vals[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_val = vals[i];
    end else begin : g_inner
      assign next_val = vals[i+1];
    end

    rmth_cell #(
      .IS_MAX(IS_MAX)
    ) u_cell (
      .clk      (clk),
      .cmd      (cell_cmd),
      .occ      (occ),
      .prev_stay(prev_stay),
      .prev_val (prev_val),
      .next_val (next_val),
      .val_r    (vals[i]),
      .stay     (stays[i])
    );
  end

  assign top  = vals[0];
  assign size = size_r;

endmodule

// ===== sv/running_median_two_heaps_unit.sv =====
// Running median unit: two sorted cell chains around a current median.
//
// Each input beat carries a sample (or a restart) and yields one output beat with the
// median, the number of samples taken and a status code. The lower and upper halves
// are held in two chains of cells kept in sorted order, so an insert or a removal of
// the top is one register update of the cells. An item is accepted in S_IDLE and its
// result is loaded into the output register in S_PUT; when the halves must be
// rebalanced it passes through S_BAL between them (the old median moves to one chain
// while the other chain's top becomes the new median). The input is ready again in
// the cycle after the load. A result waiting at the output does not hold up the next
// item's work until that item's own result is due to be loaded.
module running_median_two_heaps_unit import rmth_pkg::*; #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic                  cfg_index,
  input  logic [SAMPLE_W-1:0]   cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // [15:0] sample
  input  logic                  in_tuser,   // [0] op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] median, [26:16] sample_total
  output logic [STATUS_W-1:0]   out_tuser   // [1:0] status
);

  localparam int DEPTH  = MAX_SAMPLES / 2 + 1;
  localparam int SIZE_W = $clog2(DEPTH + 1);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BAL,
    S_PUT
  } state_t;

  state_t            state_r, state_nxt;
  val_t              median_r, median_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ended_r, ended_nxt;
  status_t           status_r, status_nxt;
  logic              bal_lower_r, bal_lower_nxt;
  val_t              acc_low_r, acc_high_r;
  logic              out_valid_r, out_valid_nxt;
  val_t              out_median_r, out_median_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;
  status_t           out_status_r, out_status_nxt;

  chain_cmd_t        lo_cmd, up_cmd;
  val_t              lo_top, up_top;
  logic [SIZE_W-1:0] lo_size, up_size;

  logic              in_fire;
  val_t              s;
  logic [CNT_W+TOTAL_W-1:0] total_ext;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign s         = in_tdata;
  assign total_ext = {{TOTAL_W{1'b0}}, count_r};

  always_comb begin
    state_nxt      = state_r;
    median_nxt     = median_r;
    count_nxt      = count_r;
    ended_nxt      = ended_r;
    status_nxt     = status_r;
    bal_lower_nxt  = bal_lower_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_median_nxt = out_median_r;
    out_total_nxt  = out_total_r;
    out_status_nxt = out_status_r;
    lo_cmd         = '0;
    up_cmd         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_PUT;
          if (in_tuser == OP_RESTART) begin
            lo_cmd.clear = 1'b1;
            up_cmd.clear = 1'b1;
            median_nxt   = '0;
            count_nxt    = '0;
            ended_nxt    = 1'b0;
            status_nxt   = ST_RESTARTED;
          end else if (ended_r || (count_r >= CNT_W'(MAX_SAMPLES))) begin
            status_nxt = ST_IGNORED;
          end else if ((s < acc_low_r) || (s > acc_high_r)) begin
            ended_nxt  = 1'b1;
            status_nxt = ST_ENDED;
          end else begin
            status_nxt = ST_ACCEPTED;
            count_nxt  = count_r + CNT_W'(1);
            if (count_r == '0) begin
              median_nxt = s;
            end else if (s == median_r) begin
              if (up_size <= lo_size) begin
                up_cmd.push  = 1'b1;
                up_cmd.value = s;
              end else begin
                lo_cmd.push  = 1'b1;
                lo_cmd.value = s;
              end
            end else if (s < median_r) begin
              lo_cmd.push  = 1'b1;
              lo_cmd.value = s;
              // After this push the lower side would lead by two.
              if (lo_size == up_size + SIZE_W'(1)) begin
                bal_lower_nxt = 1'b1;
                state_nxt     = S_BAL;
              end
            end else begin
              up_cmd.push  = 1'b1;
              up_cmd.value = s;
              if (up_size == lo_size + SIZE_W'(1)) begin
                bal_lower_nxt = 1'b0;
                state_nxt     = S_BAL;
              end
            end
          end
        end
      end
      S_BAL: begin
        state_nxt = S_PUT;
        if (bal_lower_r) begin
          median_nxt   = lo_top;
          lo_cmd.pop   = 1'b1;
          up_cmd.push  = 1'b1;
          up_cmd.value = median_r;
        end else begin
          median_nxt   = up_top;
          up_cmd.pop   = 1'b1;
          lo_cmd.push  = 1'b1;
          lo_cmd.value = median_r;
        end
      end
      S_PUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_median_nxt = median_r;
          out_total_nxt  = total_ext[TOTAL_W-1:0];
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      median_r    <= '0;
      count_r     <= '0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
      acc_low_r   <= ACCEPT_LOW_RESET;
      acc_high_r  <= ACCEPT_HIGH_RESET;
    end else begin
      state_r     <= state_nxt;
      median_r    <= median_nxt;
      count_r     <= count_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        if (cfg_index == CFG_ACCEPT_LOW) begin
          acc_low_r <= cfg_wdata;
        end else begin
          acc_high_r <= cfg_wdata;
        end
      end
    end
    status_r     <= status_nxt;
    bal_lower_r  <= bal_lower_nxt;
    out_median_r <= out_median_nxt;
    out_total_r  <= out_total_nxt;
    out_status_r <= out_status_nxt;
  end

  rmth_chain #(
    .DEPTH (DEPTH),
    .IS_MAX(1'b1),
    .SIZE_W(SIZE_W)
  ) u_lower (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (lo_cmd),
    .top  (lo_top),
    .size (lo_size)
  );

  rmth_chain #(
    .DEPTH (DEPTH),
    .IS_MAX(1'b0),
    .SIZE_W(SIZE_W)
  ) u_upper (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (up_cmd),
    .top  (up_top),
    .size (up_size)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - TOTAL_W - SAMPLE_W){1'b0}}, out_total_r, out_median_r};
  assign out_tuser  = out_status_r;

endmodule

// ===== sv/rmth_checker.sv =====
// Port-level assertions for the running median unit, with the bind that attaches them.
module rmth_checker import rmth_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_wen,
  input logic                  cfg_index,
  input logic [SAMPLE_W-1:0]   cfg_wdata,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [SAMPLE_W-1:0]   in_tdata,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]   out_tuser
);

  // A stalled output beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // One item is worked on at a time: after an input beat the unit is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on two cycles in a row");

  // A restart reports an empty state.
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_RESTARTED) |-> (out_tdata[26:0] == 27'd0))
    else $error("restart beat carries nonzero median or count");

  // Reset leaves no output beat pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind running_median_two_heaps_unit rmth_checker u_rmth_checker (.*);
